@@ rtl/core/chisq_pkg.sv @@
package chisq_pkg;

  // fixed field widths
  localparam int unsigned IdxW  = 6;
  localparam int unsigned CfgW  = 7;
  localparam int unsigned DataW = 32;
  localparam int unsigned SumW  = 64;

  localparam int unsigned MaxBins = 1 << IdxW;

  // residual u - x is exact in one more bit than the data
  localparam int unsigned ResW  = DataW + 1;
  // row dot product: at most MaxBins terms of about 40 bits each
  localparam int unsigned DotW  = 48;
  localparam int unsigned DotLoW = DotW / 2;
  // shared multiplier: two signed ResW operands
  localparam int unsigned ProdW = 2 * ResW;
  // dot times residual, exact, before saturation to SumW
  localparam int unsigned AccW  = DotW + ResW;
  // Q8.24 coefficient scaling
  localparam int unsigned FracShift = 24;

  localparam logic [1:0] OP_LOAD_MAT = 2'd0;
  localparam logic [1:0] OP_LOAD_BIN = 2'd1;
  localparam logic [1:0] OP_COMPUTE  = 2'd2;

  typedef enum logic [2:0] {
    OPSEL_MT,     // coef * true residual
    OPSEL_MW,     // coef * weighted residual
    OPSEL_FT_LO,  // true residual * low half of true dot
    OPSEL_FT_HI,  // true residual * high half of true dot
    OPSEL_FW_LO,
    OPSEL_FW_HI
  } chisq_opsel_e;

  typedef struct packed {
    chisq_opsel_e opsel;
    logic         acc_load;
    logic         acc_add;
  } chisq_ctl_t;

endpackage

@@ rtl/core/chisq_mac.sv @@
module chisq_mac (
  input  logic                                clk_i,
  input  chisq_pkg::chisq_ctl_t               ctl_i,
  input  logic signed [chisq_pkg::DataW-1:0]  coef_i,
  input  logic signed [chisq_pkg::ResW-1:0]   res_t_i,
  input  logic signed [chisq_pkg::ResW-1:0]   res_w_i,
  input  logic signed [chisq_pkg::DotW-1:0]   dot_t_i,
  input  logic signed [chisq_pkg::DotW-1:0]   dot_w_i,
  output logic signed [chisq_pkg::ProdW-1:0]  prod_o,
  output logic signed [chisq_pkg::SumW-1:0]   term_o,
  output logic                                term_ovf_o
);
  import chisq_pkg::*;

  logic signed [ResW-1:0]  op_a;
  logic signed [ResW-1:0]  op_b;
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_q;
  logic signed [AccW-1:0]  prod_ext;
  logic                    acc_fits;

  always_comb begin
    op_a = {coef_i[DataW-1], coef_i};
    op_b = res_t_i;
    case (ctl_i.opsel)
      OPSEL_MT: begin
        op_a = {coef_i[DataW-1], coef_i};
        op_b = res_t_i;
      end
      OPSEL_MW: begin
        op_a = {coef_i[DataW-1], coef_i};
        op_b = res_w_i;
      end
      OPSEL_FT_LO: begin
        op_a = res_t_i;
        op_b = {{(ResW-DotLoW){1'b0}}, dot_t_i[DotLoW-1:0]};
      end
      OPSEL_FT_HI: begin
        op_a = res_t_i;
        op_b = {{(ResW-(DotW-DotLoW)){dot_t_i[DotW-1]}}, dot_t_i[DotW-1:DotLoW]};
      end
      OPSEL_FW_LO: begin
        op_a = res_w_i;
        op_b = {{(ResW-DotLoW){1'b0}}, dot_w_i[DotLoW-1:0]};
      end
      OPSEL_FW_HI: begin
        op_a = res_w_i;
        op_b = {{(ResW-(DotW-DotLoW)){dot_w_i[DotW-1]}}, dot_w_i[DotW-1:DotLoW]};
      end
      default: begin
        op_a = {coef_i[DataW-1], coef_i};
        op_b = res_t_i;
      end
    endcase
  end

  assign prod_ext = {{(AccW-ProdW){prod_q[ProdW-1]}}, prod_q};

  always_ff @(posedge clk_i) begin
    prod_q <= op_a * op_b;
    if (ctl_i.acc_load) begin
      acc_q <= prod_ext;
    end else if (ctl_i.acc_add) begin
      // high partial product sits DotLoW bits up
      acc_q <= acc_q + (prod_ext <<< DotLoW);
    end
  end

  // exact product fits the sum width when all bits above it match its sign
  assign acc_fits = (acc_q[AccW-1:SumW-1] == {(AccW-SumW+1){1'b0}}) ||
                    (acc_q[AccW-1:SumW-1] == {(AccW-SumW+1){1'b1}});

  always_comb begin
    if (acc_fits) begin
      term_o = acc_q[SumW-1:0];
    end else if (acc_q[AccW-1]) begin
      term_o = {1'b1, {(SumW-1){1'b0}}};
    end else begin
      term_o = {1'b0, {(SumW-1){1'b1}}};
    end
  end

  assign term_ovf_o = !acc_fits;
  assign prod_o     = prod_q;

endmodule

@@ rtl/core/chi_square_quadratic_form.sv @@
// Channel  Direction  Handshake               Beat
// in       input      in_valid_i/in_stall_o   op, row/col index, matrix and bin values
// out      output     out_valid_o/out_stall_i bin number, running sums, difference, flags
// cfg      input      cfg_we_i                active_bins
//
// A compute first forms the residual of every bin, then for each bin walks its
// matrix row and ends with one result beat (held while out is stalled):
// every matrix entry costs two passes through the one shared 33x33 multiplier.
// Reset clears control, sums and the flag; matrix and bin stores are not cleared.
// in_stall_o is high from a compute beat until its last result beat is taken.
module chi_square_quadratic_form (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [chisq_pkg::CfgW-1:0]           cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [1:0]                           operation_i,
  input  logic [chisq_pkg::IdxW-1:0]           row_index_i,
  input  logic [chisq_pkg::IdxW-1:0]           col_index_i,
  input  logic signed [chisq_pkg::DataW-1:0]   matrix_value_i,
  input  logic signed [chisq_pkg::DataW-1:0]   unfolded_value_i,
  input  logic signed [chisq_pkg::DataW-1:0]   true_value_i,
  input  logic signed [chisq_pkg::DataW-1:0]   weighted_value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [chisq_pkg::IdxW-1:0]           bin_number_o,
  output logic signed [chisq_pkg::SumW-1:0]    chi2_true_running_o,
  output logic signed [chisq_pkg::SumW-1:0]    chi2_weighted_running_o,
  output logic signed [chisq_pkg::SumW-1:0]    chi2_difference_o,
  output logic                                 saturated_o,
  output logic                                 last_bin_o
);
  import chisq_pkg::*;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_RES_RD = 5'd1;
  localparam logic [4:0] S_RES_WR = 5'd2;
  localparam logic [4:0] S_RD     = 5'd3;
  localparam logic [4:0] S_MT     = 5'd4;
  localparam logic [4:0] S_MW     = 5'd5;
  localparam logic [4:0] S_AW     = 5'd6;
  localparam logic [4:0] S_RI     = 5'd7;
  localparam logic [4:0] S_FT0    = 5'd8;
  localparam logic [4:0] S_FT1    = 5'd9;
  localparam logic [4:0] S_FT2    = 5'd10;
  localparam logic [4:0] S_ST     = 5'd11;
  localparam logic [4:0] S_FW0    = 5'd12;
  localparam logic [4:0] S_FW1    = 5'd13;
  localparam logic [4:0] S_FW2    = 5'd14;
  localparam logic [4:0] S_SW     = 5'd15;
  localparam logic [4:0] S_DF     = 5'd16;
  localparam logic [4:0] S_OUT    = 5'd17;

  localparam logic [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
  localparam logic [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};

  // {overflow, saturated value}
  function automatic logic [SumW:0] sat_fold(input logic [SumW:0] s);
    logic ovf;
    ovf = s[SumW] ^ s[SumW-1];
    if (!ovf) begin
      return {1'b0, s[SumW-1:0]};
    end
    return {1'b1, (s[SumW] ? SumMin : SumMax)};
  endfunction

  logic [4:0]           state_q, state_d;
  logic [IdxW-1:0]      i_q, i_d;
  logic [IdxW-1:0]      j_q, j_d;
  logic signed [DotW-1:0] dot_t_q, dot_t_d, dot_w_q, dot_w_d;
  logic [SumW-1:0]      sum_t_q, sum_t_d, sum_w_q, sum_w_d;
  logic                 ovf_q, ovf_d;
  logic                 out_valid_q, out_valid_d;
  logic [SumW-1:0]      diff_q, diff_d;
  logic [CfgW-1:0]      active_bins_q;
  logic [IdxW-1:0]      n_last;
  logic                 in_accept;
  logic                 out_accept;
  logic                 is_last;

  logic [DataW-1:0]     mat_mem [MaxBins*MaxBins];
  logic [3*DataW-1:0]   bin_mem [MaxBins];
  logic [2*ResW-1:0]    res_mem [MaxBins];
  logic [DataW-1:0]     mat_rd_q;
  logic [3*DataW-1:0]   bin_rd_q;
  logic [2*ResW-1:0]    res_rd_q;
  logic [IdxW-1:0]      res_raddr;
  logic signed [ResW-1:0] res_t_new, res_w_new;

  chisq_ctl_t               ctl;
  logic signed [ProdW-1:0]  prod;
  logic signed [SumW-1:0]   term;
  logic                     term_ovf;
  logic signed [DotW-1:0]   prod_floor;
  logic [SumW:0]            add_res;
  logic [SumW:0]            diff_res;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_accept = out_valid_q && !out_stall_i;

  // active_bins of zero counts as one bin, anything past the store as all bins
  always_comb begin
    if (active_bins_q == '0) begin
      n_last = '0;
    end else if (active_bins_q > CfgW'(MaxBins)) begin
      n_last = IdxW'(MaxBins - 1);
    end else begin
      n_last = IdxW'(active_bins_q - CfgW'(1));
    end
  end

  assign is_last = (i_q == n_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_bins_q <= CfgW'(MaxBins);
    end else if (cfg_we_i) begin
      active_bins_q <= cfg_wdata_i;
    end
  end

  // stores
  assign res_raddr = (state_q == S_RI) ? i_q : j_q;
  assign res_t_new = {bin_rd_q[3*DataW-1], bin_rd_q[3*DataW-1:2*DataW]}
                   - {bin_rd_q[2*DataW-1], bin_rd_q[2*DataW-1:DataW]};
  assign res_w_new = {bin_rd_q[3*DataW-1], bin_rd_q[3*DataW-1:2*DataW]}
                   - {bin_rd_q[DataW-1], bin_rd_q[DataW-1:0]};

  always_ff @(posedge clk_i) begin
    if (in_accept && operation_i == OP_LOAD_MAT) begin
      mat_mem[{row_index_i, col_index_i}] <= matrix_value_i;
    end
    if (state_q == S_RD) begin
      mat_rd_q <= mat_mem[{i_q, j_q}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && operation_i == OP_LOAD_BIN) begin
      bin_mem[row_index_i] <= {unfolded_value_i, true_value_i, weighted_value_i};
    end
    if (state_q == S_RES_RD) begin
      bin_rd_q <= bin_mem[j_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_RES_WR) begin
      res_mem[j_q] <= {res_t_new, res_w_new};
    end
    if (state_q == S_RD || state_q == S_RI) begin
      res_rd_q <= res_mem[res_raddr];
    end
  end

  // shared multiplier and accumulator
  always_comb begin
    ctl.opsel    = OPSEL_MT;
    ctl.acc_load = 1'b0;
    ctl.acc_add  = 1'b0;
    unique case (state_q)
      S_MW:         ctl.opsel = OPSEL_MW;
      S_FT0:        ctl.opsel = OPSEL_FT_LO;
      S_FT1: begin
        ctl.opsel    = OPSEL_FT_HI;
        ctl.acc_load = 1'b1;
      end
      S_FW0:        ctl.opsel = OPSEL_FW_LO;
      S_FW1: begin
        ctl.opsel    = OPSEL_FW_HI;
        ctl.acc_load = 1'b1;
      end
      S_FT2, S_FW2: ctl.acc_add = 1'b1;
      default:      ctl.opsel = OPSEL_MT;
    endcase
  end

  chisq_mac u_mac (
    .clk_i      (clk_i),
    .ctl_i      (ctl),
    .coef_i     (mat_rd_q),
    .res_t_i    (res_rd_q[2*ResW-1:ResW]),
    .res_w_i    (res_rd_q[ResW-1:0]),
    .dot_t_i    (dot_t_q),
    .dot_w_i    (dot_w_q),
    .prod_o     (prod),
    .term_o     (term),
    .term_ovf_o (term_ovf)
  );

  // arithmetic shift is floor division by 2^24
  assign prod_floor = {{(DotW-(ProdW-FracShift)){prod[ProdW-1]}}, prod[ProdW-1:FracShift]};

  always_comb begin
    if (state_q == S_ST) begin
      add_res = sat_fold({sum_t_q[SumW-1], sum_t_q} + {term[SumW-1], term});
    end else begin
      add_res = sat_fold({sum_w_q[SumW-1], sum_w_q} + {term[SumW-1], term});
    end
    diff_res = sat_fold({sum_w_q[SumW-1], sum_w_q} - {sum_t_q[SumW-1], sum_t_q});
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    j_d         = j_q;
    dot_t_d     = dot_t_q;
    dot_w_d     = dot_w_q;
    sum_t_d     = sum_t_q;
    sum_w_d     = sum_w_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q;
    diff_d      = diff_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept && operation_i == OP_COMPUTE) begin
          j_d     = '0;
          state_d = S_RES_RD;
        end
      end
      S_RES_RD: state_d = S_RES_WR;
      S_RES_WR: begin
        if (j_q == n_last) begin
          i_d     = '0;
          j_d     = '0;
          dot_t_d = '0;
          dot_w_d = '0;
          sum_t_d = '0;
          sum_w_d = '0;
          ovf_d   = 1'b0;
          state_d = S_RD;
        end else begin
          j_d     = j_q + IdxW'(1);
          state_d = S_RES_RD;
        end
      end
      S_RD: state_d = S_MT;
      S_MT: state_d = S_MW;
      S_MW: begin
        dot_t_d = dot_t_q + prod_floor;
        state_d = S_AW;
      end
      S_AW: begin
        dot_w_d = dot_w_q + prod_floor;
        if (j_q == n_last) begin
          j_d     = '0;
          state_d = S_RI;
        end else begin
          j_d     = j_q + IdxW'(1);
          state_d = S_RD;
        end
      end
      S_RI:  state_d = S_FT0;
      S_FT0: state_d = S_FT1;
      S_FT1: state_d = S_FT2;
      S_FT2: state_d = S_ST;
      S_ST: begin
        sum_t_d = add_res[SumW-1:0];
        ovf_d   = ovf_q | term_ovf | add_res[SumW];
        state_d = S_FW0;
      end
      S_FW0: state_d = S_FW1;
      S_FW1: state_d = S_FW2;
      S_FW2: state_d = S_SW;
      S_SW: begin
        sum_w_d = add_res[SumW-1:0];
        ovf_d   = ovf_q | term_ovf | add_res[SumW];
        state_d = S_DF;
      end
      S_DF: begin
        // difference saturates without touching the flag
        diff_d      = diff_res[SumW-1:0];
        out_valid_d = 1'b1;
        state_d     = S_OUT;
      end
      S_OUT: begin
        if (out_accept) begin
          out_valid_d = 1'b0;
          if (is_last) begin
            state_d = S_IDLE;
          end else begin
            i_d     = i_q + IdxW'(1);
            dot_t_d = '0;
            dot_w_d = '0;
            state_d = S_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      sum_t_q     <= '0;
      sum_w_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      j_q         <= j_d;
      sum_t_q     <= sum_t_d;
      sum_w_q     <= sum_w_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dot_t_q <= dot_t_d;
    dot_w_q <= dot_w_d;
    diff_q  <= diff_d;
  end

  assign out_valid_o             = out_valid_q;
  assign bin_number_o            = i_q;
  assign chi2_true_running_o     = sum_t_q;
  assign chi2_weighted_running_o = sum_w_q;
  assign chi2_difference_o       = diff_q;
  assign saturated_o             = ovf_q;
  assign last_bin_o              = is_last;

`ifndef SYNTHESIS
  a_no_input_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while a result is pending");

  a_compute_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && operation_i == OP_COMPUTE) |=> in_stall_o)
    else $error("compute beat did not start the sequencer");

  a_last_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_bin_o) |=> !in_stall_o)
    else $error("not idle after the last bin");

  a_no_repeat_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i) |=> !out_valid_o)
    else $error("result beat repeated");
`endif

endmodule
